@@ rtl/core/bary_pkg.sv @@
// Shared types and constants for the triangle point-to-barycentric block.
// No dependencies; every other file of the block depends on this package.
package bary_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int DIFF_W        = IN_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int TOL_W         = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;
    localparam int OUT_W         = 18;
    localparam int FIFO_DEPTH    = 8;
    localparam int FRONT_STAGES  = 3;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic signed [SUM_W-1:0] det;
        logic signed [SUM_W-1:0] num_a;
        logic signed [SUM_W-1:0] num_b;
        logic                    degenerate;
    } front_item_t;

    // Occupancy the front reports so the top can throttle start.
    typedef struct packed {
        logic [1:0] inflight;
    } front_status_t;

endpackage

@@ rtl/core/bary_front.sv @@
// Front part: accept an item, form edge differences, products and sums.
// Depends on bary_pkg.
module bary_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_a_x,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_a_y,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_b_x,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_b_y,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_c_x,
    input  logic signed [bary_pkg::IN_W-1:0] vertex_c_y,
    input  logic signed [bary_pkg::IN_W-1:0] point_x,
    input  logic signed [bary_pkg::IN_W-1:0] point_y,
    output logic                          push,
    output bary_pkg::front_item_t         item,
    output bary_pkg::front_status_t       status
);
    import bary_pkg::*;

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [DIFF_W-1:0] d_acx_reg, d_bcy_reg, d_cbx_reg, d_acy_reg;
    logic signed [DIFF_W-1:0] d_pcx_reg, d_pcy_reg, d_cay_reg;
    logic signed [PROD_W-1:0] p_det0_reg, p_det1_reg, p_a0_reg, p_a1_reg;
    logic signed [PROD_W-1:0] p_b0_reg, p_b1_reg;
    front_item_t item_reg, item_next;

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [IN_W-1:0] x,
        input logic signed [IN_W-1:0] y
    );
        return DIFF_W'(x) - DIFF_W'(y);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_acx_reg <= diff(vertex_a_x, vertex_c_x);
        d_bcy_reg <= diff(vertex_b_y, vertex_c_y);
        d_cbx_reg <= diff(vertex_c_x, vertex_b_x);
        d_acy_reg <= diff(vertex_a_y, vertex_c_y);
        d_pcx_reg <= diff(point_x, vertex_c_x);
        d_pcy_reg <= diff(point_y, vertex_c_y);
        d_cay_reg <= diff(vertex_c_y, vertex_a_y);

        p_det0_reg <= PROD_W'(d_acx_reg) * PROD_W'(d_bcy_reg);
        p_det1_reg <= PROD_W'(d_cbx_reg) * PROD_W'(d_acy_reg);
        p_a0_reg   <= PROD_W'(d_bcy_reg) * PROD_W'(d_pcx_reg);
        p_a1_reg   <= PROD_W'(d_cbx_reg) * PROD_W'(d_pcy_reg);
        p_b0_reg   <= PROD_W'(d_cay_reg) * PROD_W'(d_pcx_reg);
        p_b1_reg   <= PROD_W'(d_acx_reg) * PROD_W'(d_pcy_reg);

        item_reg <= item_next;
    end

    always_comb
    begin
        item_next.det        = SUM_W'(p_det0_reg) + SUM_W'(p_det1_reg);
        item_next.num_a      = SUM_W'(p_a0_reg) + SUM_W'(p_a1_reg);
        item_next.num_b      = SUM_W'(p_b0_reg) + SUM_W'(p_b1_reg);
        item_next.degenerate = (item_next.det == '0);
    end

    assign push            = s3_v_reg;
    assign item            = item_reg;
    assign status.inflight = 2'({1'b0, s1_v_reg} + {1'b0, s2_v_reg} + {1'b0, s3_v_reg});

endmodule

@@ rtl/core/bary_fifo.sv @@
// Short queue between the front and back parts.
// Depends on bary_pkg for the item type.
module bary_fifo #(
    parameter int DEPTH = bary_pkg::FIFO_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bary_pkg::front_item_t         push_item,
    input  logic                          pop,
    output bary_pkg::front_item_t         head,
    output logic                          empty,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import bary_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    front_item_t    mem [DEPTH];
    front_item_t    head_reg;
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rd_ptr_next = (pop && !empty) ? bump(rd_ptr_reg) : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
        // Hold the entry at the next read address; pass an item straight
        // through when it lands in that slot.
        if (push && (wr_ptr_reg == rd_ptr_next))
            head_reg <= push_item;
        else
            head_reg <= mem[rd_ptr_next];
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && !empty)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = head_reg;
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

@@ rtl/core/bary_div.sv @@
// Pipelined restoring divider: signed round(num * 2^FB / den), one quotient bit per stage.
// Depends on bary_pkg for operand widths.
module bary_div #(
    parameter int FRAC_BITS = bary_pkg::FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [bary_pkg::SUM_W-1:0]  num,
    input  logic signed [bary_pkg::SUM_W-1:0]  den,
    output logic                               out_valid,
    output logic signed [FRAC_BITS+3:0]        quot
);
    import bary_pkg::*;

    localparam int NW    = SUM_W;
    localparam int STEPS = FRAC_BITS + 2;
    localparam int QW    = STEPS;
    localparam int RW    = NW + FRAC_BITS + 1;

    logic [RW-1:0] r_reg   [STEPS+1];
    logic [QW-1:0] q_reg   [STEPS+1];
    logic [NW-1:0] d_reg   [STEPS+1];
    logic [STEPS:0] neg_reg, ovf_reg, v_reg;
    logic          out_v_reg;
    logic signed [QW+1:0] quot_reg;

    logic [NW-1:0] num_mag, den_mag;
    logic [QW:0]   mag;
    logic          rnd;

    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[NW-1] ? NW'(-den) : NW'(den);

    // Quotients at or above 2^(FB+2) lie far outside any clamp window: saturate.
    always_ff @(posedge clk)
    begin
        r_reg[0]   <= RW'(num_mag) << FRAC_BITS;
        q_reg[0]   <= '0;
        d_reg[0]   <= den_mag;
        neg_reg[0] <= num[NW-1] ^ den[NW-1];
        ovf_reg[0] <= ({2'b00, num_mag} >= {den_mag, 2'b00});
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;
        logic [RW-1:0] dsh;
        assign dsh = RW'(d_reg[k]) << BIT;
        always_ff @(posedge clk)
        begin
            if (r_reg[k] >= dsh)
            begin
                r_reg[k+1] <= r_reg[k] - dsh;
                q_reg[k+1] <= q_reg[k] | (QW'(1) << BIT);
            end
            else
            begin
                r_reg[k+1] <= r_reg[k];
                q_reg[k+1] <= q_reg[k];
            end
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[STEPS-1:0], in_valid};
            out_v_reg <= v_reg[STEPS];
        end
    end

    assign rnd = ({r_reg[STEPS], 1'b0} >= (RW + 1)'(d_reg[STEPS]));
    assign mag = ovf_reg[STEPS] ? ((QW + 1)'(1) << QW)
                                : {1'b0, q_reg[STEPS]} + (QW + 1)'(rnd);

    always_ff @(posedge clk)
    begin
        quot_reg <= neg_reg[STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign out_valid = out_v_reg;
    assign quot      = quot_reg;

endmodule

@@ rtl/core/bary_back.sv @@
// Back part: two dividers, clamp against tolerance, sum fix, third weight, output format.
// Depends on bary_pkg and bary_div.
module bary_back #(
    parameter int FRAC_BITS = bary_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  bary_pkg::front_item_t                item,
    input  logic [bary_pkg::TOL_W-1:0]           tolerance,
    output logic                                 result_valid,
    output logic signed [bary_pkg::OUT_W-1:0]    weight_a,
    output logic signed [bary_pkg::OUT_W-1:0]    weight_b,
    output logic signed [bary_pkg::OUT_W-1:0]    weight_c,
    output logic                                 is_inside,
    output logic                                 degenerate
);
    import bary_pkg::*;

    localparam int QW   = FRAC_BITS + 4;
    localparam int CW   = FRAC_BITS + 6;
    localparam int DL   = FRAC_BITS + 4;
    localparam int TSL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int TSR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int XW   = TOL_W + TSL + CW;
    localparam int SH   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int SL   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int OW   = CW + SL + 1;
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;
    localparam logic signed [OW-1:0] RND = (FRAC_BITS > 16) ? (OW'(1) << (SH - 1)) : '0;
    localparam logic signed [OW-1:0] OMAX = OW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [OW-1:0] OMIN = -OW'(1 << (OUT_W - 1));

    logic dv_a, dv_b;
    logic signed [QW-1:0] q_a, q_b;
    logic [DL-1:0] deg_pipe_reg;

    logic signed [CW-1:0] tol_c;
    logic [XW-1:0]        tol_x;

    logic                 va_reg, vb_reg, vc_reg;
    logic signed [CW-1:0] wa0_reg, wa1_reg, wb0_reg, wb1_reg;
    logic                 ina_reg, inb_reg, dega_reg, degb_reg;
    logic signed [CW-1:0] wa0_next, wa1_next, wb0_next, wb1_next;
    logic                 ina_next, inb_next;
    logic signed [CW-1:0] sum_b, exc_b, half_b, wc_c;
    logic signed [OUT_W-1:0] wa_reg, wb_reg, wc_reg;
    logic                 inside_reg, deg_reg;

    bary_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .num       (item.num_a),
        .den       (item.det),
        .out_valid (dv_a),
        .quot      (q_a)
    );

    bary_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .num       (item.num_b),
        .den       (item.det),
        .out_valid (dv_b),
        .quot      (q_b)
    );

    always_ff @(posedge clk)
    begin
        deg_pipe_reg <= {deg_pipe_reg[DL-2:0], item.degenerate};
    end

    assign tol_x = (XW'(tolerance) << TSL) >> TSR;
    assign tol_c = $signed(tol_x[CW-1:0]);

    function automatic logic signed [CW-1:0] clamp_w(
        input  logic signed [CW-1:0] w,
        input  logic signed [CW-1:0] tol,
        output logic                 outside
    );
        outside = 1'b1;
        if (w < -tol)
            return '0;
        else if (w > ONE + tol)
            return ONE;
        outside = 1'b0;
        return w;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [OW-1:0] o;
        o = ((OW'(v) + RND) >>> SH) <<< SL;
        if (o > OMAX)
            o = OMAX;
        else if (o < OMIN)
            o = OMIN;
        return o[OUT_W-1:0];
    endfunction

    // Clamp stage.
    always_comb
    begin
        logic oa, ob;
        wa0_next = clamp_w(CW'(q_a), tol_c, oa);
        wa1_next = clamp_w(CW'(q_b), tol_c, ob);
        ina_next = !(oa || ob);
    end

    // Sum-above-one fix stage: take half the excess from each weight.
    always_comb
    begin
        sum_b    = wa0_reg + wa1_reg;
        exc_b    = sum_b - ONE;
        half_b   = exc_b >>> 1;
        wb0_next = wa0_reg;
        wb1_next = wa1_reg;
        inb_next = ina_reg;
        if (sum_b > ONE)
        begin
            wb0_next = wa0_reg - (exc_b - half_b);
            wb1_next = wa1_reg - half_b;
            inb_next = 1'b0;
        end
    end

    assign wc_c = ONE - wb0_reg - wb1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= dv_a && dv_b;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wa0_reg  <= wa0_next;
        wa1_reg  <= wa1_next;
        ina_reg  <= ina_next;
        dega_reg <= deg_pipe_reg[DL-1];

        wb0_reg  <= wb0_next;
        wb1_reg  <= wb1_next;
        inb_reg  <= inb_next;
        degb_reg <= dega_reg;

        if (degb_reg)
        begin
            wa_reg     <= '0;
            wb_reg     <= '0;
            wc_reg     <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            wa_reg     <= to_out(wb0_reg);
            wb_reg     <= to_out(wb1_reg);
            wc_reg     <= to_out(wc_c);
            inside_reg <= inb_reg;
        end
        deg_reg <= degb_reg;
    end

    assign result_valid = vc_reg;
    assign weight_a     = wa_reg;
    assign weight_b     = wb_reg;
    assign weight_c     = wc_reg;
    assign is_inside    = inside_reg;
    assign degenerate   = deg_reg;

endmodule

@@ rtl/core/triangle_point_to_barycentric_top.sv @@
// Top level of the triangle point-to-barycentric block.
// Depends on bary_pkg, bary_front, bary_fifo, bary_back.
//
// Usage:
//   Drive the eight Q16.16 coordinates and raise start; the item is taken at
//   every rising edge where start is high and busy is low. busy stays low in
//   steady operation, so one item can be issued every cycle.
//   Each item yields exactly one result: result_valid pulses for one cycle
//   with weight_a/b/c (signed Q2.16), is_inside and degenerate. The receiver
//   must take the result in that cycle; there is no backpressure.
//   From the accepting edge to the result, an item passes three front stages
//   (differences, 33x33 products, sums), the queue's head register,
//   FRAC_BITS + 4 divider stages (operand setup, one quotient bit per step,
//   sign and rounding; both weights in parallel) and three back stages
//   (clamp, sum fix, third weight and output format).
//   The tolerance register is written through cfg_valid/cfg_ready/cfg_data;
//   the user must do so only while no item is in flight, which the block does
//   not enforce; cfg_ready is always high.
//   Reset (rst_n low, asynchronous) drops every item in flight, empties the
//   queue and loads the tolerance with its default of 66 (about 0.001).
module triangle_point_to_barycentric_top #(
    parameter int FRAC_BITS = bary_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_a_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_a_y,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_b_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_b_y,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_c_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_c_y,
    input  logic signed [bary_pkg::IN_W-1:0]    point_x,
    input  logic signed [bary_pkg::IN_W-1:0]    point_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bary_pkg::TOL_W-1:0]          cfg_data,
    output logic                                result_valid,
    output logic signed [bary_pkg::OUT_W-1:0]   weight_a,
    output logic signed [bary_pkg::OUT_W-1:0]   weight_b,
    output logic signed [bary_pkg::OUT_W-1:0]   weight_c,
    output logic                                is_inside,
    output logic                                degenerate
);
    import bary_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic              accept;
    logic              push;
    front_item_t       front_item, head_item;
    front_status_t     front_stat;
    logic              q_empty;
    logic [CNT_W-1:0]  q_count;
    logic [CNT_W:0]    occupancy;
    logic [TOL_W-1:0]  tol_reg;

    // Hold off start only if the queue could overflow with items still in the front.
    assign occupancy = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(front_stat.inflight);
    assign busy      = (occupancy >= (CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = start && !busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    bary_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .point_x    (point_x),
        .point_y    (point_y),
        .push       (push),
        .item       (front_item),
        .status     (front_stat)
    );

    // The back part never stalls, so pop the head whenever there is one.
    bary_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (!q_empty),
        .head      (head_item),
        .empty     (q_empty),
        .count     (q_count)
    );

    bary_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (!q_empty),
        .item         (head_item),
        .tolerance    (tol_reg),
        .result_valid (result_valid),
        .weight_a     (weight_a),
        .weight_b     (weight_b),
        .weight_c     (weight_c),
        .is_inside    (is_inside),
        .degenerate   (degenerate)
    );

endmodule

@@ rtl/core/bary_checker.sv @@
// Port-level checks for the triangle point-to-barycentric block, bound to the top.
// Depends on bary_pkg and triangle_point_to_barycentric_top.
module bary_checker #(
    parameter int FRAC_BITS = bary_pkg::FRAC_BITS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic                               result_valid,
    input logic signed [bary_pkg::OUT_W-1:0]  weight_a,
    input logic signed [bary_pkg::OUT_W-1:0]  weight_b,
    input logic signed [bary_pkg::OUT_W-1:0]  weight_c,
    input logic                               is_inside,
    input logic                               degenerate
);
    // Edges from the accepting edge to the edge that takes the result.
    localparam int LAT = FRAC_BITS + 11;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT result_valid)
        else $error("accepted item produced no result");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && degenerate) |->
            (weight_a == '0 && weight_b == '0 && weight_c == '0 && !is_inside))
        else $error("degenerate result with nonzero weights");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind triangle_point_to_barycentric_top bary_checker #(.FRAC_BITS(FRAC_BITS)) u_bary_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .weight_a     (weight_a),
    .weight_b     (weight_b),
    .weight_c     (weight_c),
    .is_inside    (is_inside),
    .degenerate   (degenerate)
);

@@ tb/bary_checker.sv @@
// Checker for the triangle point-to-barycentric block: predicts each result and compares.
// Depends on bary_pkg; watches the start/busy, configuration and result channels.
module bary_scoreboard #(
    parameter int FRAC_BITS = bary_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_a_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_a_y,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_b_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_b_y,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_c_x,
    input  logic signed [bary_pkg::IN_W-1:0]    vertex_c_y,
    input  logic signed [bary_pkg::IN_W-1:0]    point_x,
    input  logic signed [bary_pkg::IN_W-1:0]    point_y,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bary_pkg::TOL_W-1:0]          cfg_data,
    input  logic                                result_valid,
    input  logic signed [bary_pkg::OUT_W-1:0]   weight_a,
    input  logic signed [bary_pkg::OUT_W-1:0]   weight_b,
    input  logic signed [bary_pkg::OUT_W-1:0]   weight_c,
    input  logic                                is_inside,
    input  logic                                degenerate,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  result_count,
    output int                                  outside_count,
    output int                                  degen_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bary_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] wa;
        logic signed [OUT_W-1:0] wb;
        logic signed [OUT_W-1:0] wc;
        logic                    in_tri;
        logic                    degen;
    } weights_t;

    weights_t      weights_q[$];
    logic [TOL_W-1:0] tol_reg;

    // Rounded signed num * 2^FRAC_BITS / den, ties away from zero, magnitude held at 2^40.
    function automatic longint scaled_ratio(logic signed [127:0] num, logic signed [127:0] den);
        logic         neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        n = n << FRAC_BITS;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d)
            q = q + 1;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_q2_16(longint v);
        longint o;
        if (FRAC_BITS > 16)
            o = (v + (longint'(1) <<< (FRAC_BITS - 17))) >>> (FRAC_BITS - 16);
        else
            o = v * (longint'(1) <<< (16 - FRAC_BITS));
        if (o > 131071)
            o = 131071;
        if (o < -131072)
            o = -131072;
        return o[OUT_W-1:0];
    endfunction

    function automatic weights_t predict_weights(longint ax, longint ay, longint bx, longint by,
                                                 longint cx, longint cy, longint px, longint py);
        logic signed [127:0] det;
        logic signed [127:0] na;
        logic signed [127:0] nb;
        longint   one;
        longint   tol;
        longint   w[2];
        longint   e;
        weights_t res;
        one = longint'(1) <<< FRAC_BITS;
        det = 128'(ax - cx) * 128'(by - cy) + 128'(cx - bx) * 128'(ay - cy);
        res = '0;
        if (det == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        na = 128'(by - cy) * 128'(px - cx) + 128'(cx - bx) * 128'(py - cy);
        nb = 128'(cy - ay) * 128'(px - cx) + 128'(ax - cx) * 128'(py - cy);
        w[0] = scaled_ratio(na, det);
        w[1] = scaled_ratio(nb, det);
        if (FRAC_BITS >= 16)
            tol = longint'(tol_reg) <<< (FRAC_BITS - 16);
        else
            tol = longint'(tol_reg) >>> (16 - FRAC_BITS);
        res.in_tri = 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            if (w[i] < -tol)
            begin
                w[i] = 0;
                res.in_tri = 1'b0;
            end
            else if (w[i] > one + tol)
            begin
                w[i] = one;
                res.in_tri = 1'b0;
            end
        end
        if (w[0] + w[1] > one)
        begin
            e = w[0] + w[1] - one;
            w[0] -= e - (e >>> 1);
            w[1] -= e >>> 1;
            res.in_tri = 1'b0;
        end
        res.wa = to_q2_16(w[0]);
        res.wb = to_q2_16(w[1]);
        res.wc = to_q2_16(one - w[0] - w[1]);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        weights_t want;
        if (!rst_n)
        begin
            tol_reg = TOL_RESET;
            weights_q.delete();
            fail_count = 0;
            result_count = 0;
            outside_count = 0;
            degen_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                result_count++;
                if (weights_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = weights_q.pop_front();
                    if (weight_a !== want.wa)
                        report_mismatch("weight_a", weight_a, want.wa);
                    if (weight_b !== want.wb)
                        report_mismatch("weight_b", weight_b, want.wb);
                    if (weight_c !== want.wc)
                        report_mismatch("weight_c", weight_c, want.wc);
                    if (is_inside !== want.in_tri)
                        report_mismatch("is_inside", is_inside, want.in_tri);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                    if (!want.in_tri)
                        outside_count++;
                    if (want.degen)
                        degen_count++;
                end
            end
            if (start && !busy)
                weights_q.push_back(predict_weights(vertex_a_x, vertex_a_y, vertex_b_x,
                    vertex_b_y, vertex_c_x, vertex_c_y, point_x, point_y));
            // A new tolerance only applies to items taken after the write.
            if (cfg_valid && cfg_ready)
                tol_reg = cfg_data;
        end
        pending = weights_q.size();
    end
endmodule

@@ tb/triangle_point_to_barycentric_top_tb.sv @@
// Testbench top for the triangle point-to-barycentric block: clock, reset, stimulus, verdict.
// Depends on bary_pkg, the block's RTL and bary_scoreboard.
module triangle_point_to_barycentric_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bary_pkg::*;

    localparam int LATENCY   = FRAC_BITS_DEF + 11;
    localparam int WATCHDOG  = 4000;
    localparam int N_RANDOM  = 1650;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [IN_W-1:0] vertex_a_x = '0;
    logic signed [IN_W-1:0] vertex_a_y = '0;
    logic signed [IN_W-1:0] vertex_b_x = '0;
    logic signed [IN_W-1:0] vertex_b_y = '0;
    logic signed [IN_W-1:0] vertex_c_x = '0;
    logic signed [IN_W-1:0] vertex_c_y = '0;
    logic signed [IN_W-1:0] point_x = '0;
    logic signed [IN_W-1:0] point_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;
    logic result_valid;
    logic signed [OUT_W-1:0] weight_a;
    logic signed [OUT_W-1:0] weight_b;
    logic signed [OUT_W-1:0] weight_c;
    logic is_inside;
    logic degenerate;

    int fail_count;
    int pending;
    int result_count;
    int outside_count;
    int degen_count;
    int idle_pct;
    int quiet_cycles;

    always #10 clk = ~clk;

    triangle_point_to_barycentric_top dut (.*);

    bary_scoreboard checker_i (.*);

    // Watchdog: count cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one triangle and point; hold start until the block takes it.
    // Random idle cycles go in front at the current idle rate.
    task automatic send_triangle(logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
                                 logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
                                 logic [IN_W-1:0] cx, logic [IN_W-1:0] cy,
                                 logic [IN_W-1:0] px, logic [IN_W-1:0] py);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        vertex_a_x <= ax;
        vertex_a_y <= ay;
        vertex_b_x <= bx;
        vertex_b_y <= by;
        vertex_c_x <= cx;
        vertex_c_y <= cy;
        point_x <= px;
        point_y <= py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drain: drop start, wait for every expected result, then pad with the latency.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write the tolerance while the block is idle.
    task automatic write_tolerance(logic [TOL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Small coordinate in Q16.16, within plus or minus 4 units, to land near the triangle.
    function automatic logic [IN_W-1:0] near_coord();
        return IN_W'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endfunction

    function automatic logic [IN_W-1:0] any_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            default: return near_coord();
        endcase
    endfunction

    // Random triangle and point: mostly compact shapes with points near or inside,
    // some degenerate (collinear or repeated vertices), some with wild coordinates.
    task automatic send_random_triangle();
        logic [IN_W-1:0] c[8];
        logic signed [IN_W-1:0] s;
        int kind;
        kind = $urandom_range(99);
        foreach (c[i])
            c[i] = (kind < 75) ? near_coord() : any_coord();
        if (kind < 8)
        begin
            // Collinear: c = a + k(b - a), integer k.
            s = $signed($urandom_range(0, 6)) - 3;
            c[4] = c[0] + s * (c[2] - c[0]);
            c[5] = c[1] + s * (c[3] - c[1]);
        end
        else if (kind < 12)
        begin
            c[2] = c[0];
            c[3] = c[1];
        end
        else if (kind < 40)
        begin
            // Point at a vertex, an edge midpoint or just beside a vertex, edge cases of the inside test.
            case ($urandom_range(2))
                0: begin c[6] = c[0]; c[7] = c[1]; end
                1: begin c[6] = c[2] + $signed(c[4] - c[2]) / 2;
                         c[7] = c[3] + $signed(c[5] - c[3]) / 2; end
                default: begin c[6] = c[4] + $signed($urandom_range(0, 8)) - 4;
                               c[7] = c[5] + $signed($urandom_range(0, 8)) - 4; end
            endcase
        end
        send_triangle(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial
    begin
        idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset tolerance: unit triangle and extremes.
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h4000, 32'h4000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8000, 32'h8000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'hFFFF_FFFF, 32'h4000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h20000, 32'h20000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8001, 32'h8001);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_triangle(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h4000, 32'h4000);
        send_triangle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_triangle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_triangle(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_triangle(5, 5, 5, 5, 5, 5, 0, 0);
        send_triangle(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 1, 1);
        send_triangle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 0);
        drain_results();

        // Extreme tolerances: full slack lets weights run out of Q2.16 range.
        write_tolerance(16'hFFFF);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'hFFFF_4000, 32'h4000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h18000, 32'h0);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8000_0000, 32'h8000_0000);
        drain_results();
        write_tolerance(16'h0000);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'hFFFF_FFFF, 0);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8000, 32'h8000);
        drain_results();

        // Random part in phases of tolerance and idle rate; the drain between
        // phases also makes the sender pause until every result is back.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_tolerance(TOL_RESET);
                1: write_tolerance(16'h0000);
                2: write_tolerance(16'hFFFF);
                default: write_tolerance($urandom_range(0, 16'hFFFF));
            endcase
            idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 46 : 28);
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_random_triangle();
            drain_results();
        end

        $display("Ran %0d results: %0d outside or clamped, %0d degenerate triangles,",
                 result_count, outside_count, degen_count);
        $display("across six tolerance settings including zero and full scale.");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
